// ===== rtl/digram_grammar_builder_defines.svh =====
// Assertion macros shared by the grammar builder RTL.
// Depends on nothing; included by the top level.
`ifndef DIGRAM_GRAMMAR_BUILDER_DEFINES_SVH
`define DIGRAM_GRAMMAR_BUILDER_DEFINES_SVH
// implication checked at every clock edge outside reset
`define DGB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define DGB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/dgb_pkg.sv =====
// Shared constants and types for the digram grammar builder.
// No dependencies.
package dgb_pkg;
  localparam int unsigned GrammarDepth = 65536;
  localparam int unsigned HashPrime    = 131071;
  localparam int unsigned RingDepth    = 16384;
  localparam logic [7:0]  SpaceCode    = 8'd32;
  localparam int unsigned FirstPos     = 256;
  localparam int unsigned SentinelPos  = 255;

  typedef enum logic [4:0] {
    ST_CLR, ST_SENT, ST_SENT_W, ST_IDLE, ST_WRITE, ST_RD_A, ST_RD_B, ST_KEY,
    ST_MOD, ST_PROBE_RD, ST_PROBE_CHK, ST_CAND_RD, ST_CAND_CHK,
    ST_POP_RING, ST_POP_CLR, ST_REG, ST_DONE, ST_OUT
  } state_e;
endpackage

// ===== rtl/dgb_if.sv =====
// Valid/ready channel interfaces for the digram grammar builder.
// Depends on nothing.
interface dgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface dgb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] top_position;
  logic [16:0] top_symbol;
  logic [15:0] replacement_count;
  logic        segment_full;
  modport source (output valid, output top_position, output top_symbol,
                  output replacement_count, output segment_full, input ready);
  modport sink   (input valid, input top_position, input top_symbol,
                  input replacement_count, input segment_full, output ready);
endinterface

// ===== rtl/digram_grammar_builder.sv =====
// Digram grammar builder: top level, sequencer and state memories.
// Depends on dgb_pkg, dgb_if.sv and digram_grammar_builder_defines.svh.
//
// channel  | dir | transaction
// in_if    | in  | one data_byte appended to the grammar
// out_if   | out | top_position, top_symbol, replacement_count, segment_full
//
// Sequence: after the accepting cycle, the digram is fetched and its key
// formed, the key is reduced by both moduli with reciprocals (estimate,
// remainder, fix-up), the table is probed, then register, done and output.
// A further probe adds a candidate check, with a candidate fetch and a second
// fetch when only the lower symbol differs. A pop starts a new round.
// Reset: a clearing pass over the digram table clears table and ring, then
// the sentinel is registered; the same pass runs at every segment end. No
// input is taken meanwhile.
// Stalls: a finished result waits in ST_OUT only while the output register
// still holds an unaccepted transaction; no byte is taken meanwhile.
`include "digram_grammar_builder_defines.svh"
module digram_grammar_builder #(
  parameter int unsigned GRAMMAR_DEPTH = dgb_pkg::GrammarDepth,
  parameter int unsigned HASH_PRIME    = dgb_pkg::HashPrime,
  parameter int unsigned RING_DEPTH    = dgb_pkg::RingDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  dgb_in_if.sink    in_if,
  dgb_out_if.source out_if
);
  localparam int GW = $clog2(GRAMMAR_DEPTH);     // grammar index width
  localparam int SW = GW + 1;                    // symbol width
  localparam int HW = $clog2(HASH_PRIME + 1);    // table index width
  localparam int RW = $clog2(RING_DEPTH);
  localparam int KW = 32;
  localparam logic [HW-1:0] HP = HW'(HASH_PRIME);
  // moduli and their truncated reciprocals (quotient estimate is low by <= 1)
  localparam logic [KW-1:0] P1 = KW'(HASH_PRIME);
  localparam logic [KW-1:0] P2 = KW'(HASH_PRIME - 1);
  localparam logic [KW-1:0] M1 = KW'((64'd1 << KW) / 64'(HASH_PRIME));
  localparam logic [KW-1:0] M2 = KW'((64'd1 << KW) / 64'(HASH_PRIME - 1));

  // memories: grammar store, digram table, slot ring
  logic [SW-1:0] gmem [GRAMMAR_DEPTH];
  logic [GW-1:0] tmem [HASH_PRIME + 1];
  logic [HW:0]   rmem [RING_DEPTH];

  logic          g_we;  logic [GW-1:0] g_wa, g_ra;  logic [SW-1:0] g_wd, g_rd_q;
  logic          t_we;  logic [HW-1:0] t_wa, t_ra;  logic [GW-1:0] t_wd, t_rd_q;
  logic          r_we;  logic [RW-1:0] r_wa, r_ra;  logic [HW:0]   r_wd, r_rd_q;

  always_ff @(posedge clk_i) begin
    if (g_we) gmem[g_wa] <= g_wd;
    g_rd_q <= gmem[g_ra];
  end
  always_ff @(posedge clk_i) begin
    if (t_we) tmem[t_wa] <= t_wd;
    t_rd_q <= tmem[t_ra];
  end
  always_ff @(posedge clk_i) begin
    if (r_we) rmem[r_wa] <= r_wd;
    r_rd_q <= rmem[r_ra];
  end

  dgb_pkg::state_e st_q, st_d;
  logic [HW-1:0] clr_q, clr_d;          // clearing pass index
  logic          init_q, init_d;        // store sentinel needs writing
  logic [GW:0]   g_q, g_d;              // working top position
  logic [SW-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic [KW-1:0] rem1_q, rem1_d, rem2_q, rem2_d;  // reduction intermediates
  logic [5:0]    mc_q, mc_d;
  logic [HW-1:0] h1_q, h1_d, h2_q, h2_d;
  logic [HW-1:0] slot_q, slot_d;
  logic [HW:0]   tries_q, tries_d;
  logic          skip_q, skip_d;
  logic [GW-1:0] e_q, e_d;
  logic [15:0]   reps_q, reps_d;
  logic          full_q, full_d, sent_q, sent_d;
  logic          ov_q, ov_d;
  logic [15:0]   op_q, op_d; logic [16:0] os_q, os_d;
  logic [15:0]   orc_q, orc_d; logic of_q, of_d;
  // finished result waiting for the output register
  logic [15:0]   pp_q, pp_d; logic [16:0] ps_q, ps_d;
  logic [15:0]   pr_q, pr_d; logic pf_q, pf_d;

  // products and reduction steps
  logic [KW-1:0]   prod;
  logic [2*KW-1:0] qm1, qm2;
  logic [KW-1:0]   qp1, qp2, fin1, fin2;
  logic [HW:0]     hsum;
  assign prod = KW'(b_q) * KW'(a_q);
  assign qm1  = k_q * M1;
  assign qm2  = k_q * M2;
  assign qp1  = rem1_q * P1;
  assign qp2  = rem2_q * P2;
  assign fin1 = (rem1_q >= P1) ? rem1_q - P1 : rem1_q;
  assign fin2 = (rem2_q >= P2) ? rem2_q - P2 : rem2_q;
  assign hsum = {1'b0, h1_q} + {1'b0, h2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dgb_pkg::ST_CLR; clr_q <= '0; init_q <= 1'b1; ov_q <= 1'b0;
      g_q <= '0; reps_q <= '0; full_q <= 1'b0; sent_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; init_q <= init_d; ov_q <= ov_d;
      g_q <= g_d; reps_q <= reps_d; full_q <= full_d; sent_q <= sent_d;
    end
  end
  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; k_q <= k_d; rem1_q <= rem1_d; rem2_q <= rem2_d;
    mc_q <= mc_d; h1_q <= h1_d; h2_q <= h2_d; slot_q <= slot_d;
    tries_q <= tries_d; skip_q <= skip_d; e_q <= e_d;
    op_q <= op_d; os_q <= os_d; orc_q <= orc_d; of_q <= of_d;
    pp_q <= pp_d; ps_q <= ps_d; pr_q <= pr_d; pf_q <= pf_d;
  end

  assign in_if.ready              = (st_q == dgb_pkg::ST_IDLE);
  assign out_if.valid             = ov_q;
  assign out_if.top_position      = op_q;
  assign out_if.top_symbol        = os_q;
  assign out_if.replacement_count = orc_q;
  assign out_if.segment_full      = of_q;

  logic hit_ok;
  always_comb begin
    st_d = st_q; clr_d = clr_q; init_d = init_q; g_d = g_q; a_d = a_q; b_d = b_q;
    k_d = k_q; rem1_d = rem1_q; rem2_d = rem2_q; mc_d = mc_q; h1_d = h1_q;
    h2_d = h2_q; slot_d = slot_q; tries_d = tries_q; skip_d = skip_q;
    e_d = e_q; reps_d = reps_q; full_d = full_q; sent_d = sent_q;
    ov_d = ov_q; op_d = op_q; os_d = os_q; orc_d = orc_q; of_d = of_q;
    pp_d = pp_q; ps_d = ps_q; pr_d = pr_q; pf_d = pf_q;
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = g_q[GW-1:0];
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = h1_q;
    r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = g_q[RW-1:0];
    hit_ok = 1'b0;
    if (ov_q && out_if.ready) ov_d = 1'b0;
    case (st_q)
      dgb_pkg::ST_CLR: begin
        t_we = 1'b1; t_wa = clr_q; t_wd = '0;
        r_we = 1'b1; r_wa = clr_q[RW-1:0]; r_wd = '0;
        if (init_q) begin
          g_we = 1'b1; g_wa = GW'(dgb_pkg::SentinelPos); g_wd = SW'(GRAMMAR_DEPTH);
          if (clr_q == '0) begin
            g_wa = GW'(dgb_pkg::SentinelPos - 1); g_wd = '0;
          end
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == HP) begin
          clr_d = '0; st_d = dgb_pkg::ST_SENT;
        end
      end
      dgb_pkg::ST_SENT: begin
        // key of (0, GRAMMAR_DEPTH) is GRAMMAR_DEPTH
        init_d = 1'b0; a_d = '0; b_d = SW'(GRAMMAR_DEPTH); sent_d = 1'b1;
        g_d = (GW+1)'(dgb_pkg::SentinelPos);
        k_d = KW'(GRAMMAR_DEPTH); rem1_d = '0; rem2_d = '0; mc_d = '0;
        skip_d = 1'b0; st_d = dgb_pkg::ST_MOD;
      end
      dgb_pkg::ST_SENT_W: begin
        t_we = 1'b1; t_wa = h1_q; t_wd = GW'(dgb_pkg::SentinelPos);
        r_we = 1'b1; r_wa = RW'(dgb_pkg::SentinelPos); r_wd = {1'b0, h1_q};
        sent_d = 1'b0; g_d = (GW+1)'(dgb_pkg::FirstPos);
        st_d = full_q ? dgb_pkg::ST_OUT : dgb_pkg::ST_IDLE;
      end
      dgb_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          g_we = 1'b1; g_wa = g_q[GW-1:0]; g_wd = SW'(in_if.data_byte);
          reps_d = '0; full_d = 1'b0; st_d = dgb_pkg::ST_RD_A;
        end
      end
      dgb_pkg::ST_RD_A: begin
        g_ra = g_q[GW-1:0] - 1'b1; st_d = dgb_pkg::ST_RD_B;
      end
      dgb_pkg::ST_RD_B: begin
        a_d = g_rd_q; g_ra = g_q[GW-1:0]; st_d = dgb_pkg::ST_KEY;
      end
      dgb_pkg::ST_KEY: begin
        b_d = g_rd_q; st_d = dgb_pkg::ST_WRITE;
      end
      dgb_pkg::ST_WRITE: begin
        skip_d = (a_q == SW'(dgb_pkg::SpaceCode)) && (b_q != SW'(dgb_pkg::SpaceCode));
        k_d = (KW'(b_q) - KW'(a_q)) - prod;
        rem1_d = '0; rem2_d = '0; mc_d = '0; st_d = dgb_pkg::ST_MOD;
      end
      dgb_pkg::ST_MOD: begin
        // quotient estimate, remainder below twice the modulus, final fix-up
        mc_d = mc_q + 1'b1;
        if (mc_q == 6'd0) begin
          rem1_d = qm1[2*KW-1:KW]; rem2_d = qm2[2*KW-1:KW];
        end else if (mc_q == 6'd1) begin
          rem1_d = k_q - qp1; rem2_d = k_q - qp2;
        end else begin
          if (sent_q) begin
            h1_d = HW'(fin1); st_d = dgb_pkg::ST_SENT_W;
          end else begin
            h1_d = skip_q ? HP : HW'(fin1);
            h2_d = skip_q ? HW'(1) : HW'(fin2) + 1'b1;
            tries_d = '0; slot_d = HP; st_d = dgb_pkg::ST_PROBE_RD;
          end
        end
      end
      dgb_pkg::ST_PROBE_RD: begin
        t_ra = h1_q; st_d = dgb_pkg::ST_PROBE_CHK;
      end
      dgb_pkg::ST_PROBE_CHK: begin
        e_d = t_rd_q;
        if (t_rd_q == '0 || h1_q == HP) begin
          slot_d = h1_q; st_d = dgb_pkg::ST_REG;
        end else if (g_q > (GW+1)'(dgb_pkg::FirstPos) &&
                     {1'b0, t_rd_q} != g_q - 1'b1) begin
          g_ra = t_rd_q; st_d = dgb_pkg::ST_CAND_RD;
        end else st_d = dgb_pkg::ST_CAND_CHK;
      end
      dgb_pkg::ST_CAND_RD: begin
        if (g_rd_q == b_q) begin
          g_ra = e_q - 1'b1; st_d = dgb_pkg::ST_POP_RING;
        end else begin
          st_d = dgb_pkg::ST_CAND_CHK;
        end
      end
      dgb_pkg::ST_POP_RING: begin
        if (g_rd_q == a_q) begin
          hit_ok = 1'b1;
          g_d = g_q - 1'b1; r_ra = g_d[RW-1:0];
          g_we = 1'b1; g_wa = g_d[GW-1:0]; g_wd = SW'(e_q);
          if (reps_q != 16'hFFFF) reps_d = reps_q + 1'b1;
          st_d = dgb_pkg::ST_POP_CLR;
        end else st_d = dgb_pkg::ST_CAND_CHK;
      end
      dgb_pkg::ST_POP_CLR: begin
        if (r_rd_q <= (HW+1)'(HASH_PRIME)) begin
          t_we = 1'b1; t_wa = r_rd_q[HW-1:0]; t_wd = '0;
        end
        st_d = dgb_pkg::ST_RD_A;
      end
      dgb_pkg::ST_CAND_CHK: begin
        tries_d = tries_q + 1'b1;
        h1_d = (hsum >= (HW+1)'(HASH_PRIME)) ? HW'(hsum - (HW+1)'(HASH_PRIME)) : HW'(hsum);
        if (tries_d >= (HW+1)'(HASH_PRIME)) begin
          slot_d = HP; st_d = dgb_pkg::ST_REG;
        end else st_d = dgb_pkg::ST_PROBE_RD;
      end
      dgb_pkg::ST_REG: begin
        if (slot_q != HP) begin
          t_we = 1'b1; t_wa = slot_q; t_wd = g_q[GW-1:0];
        end
        r_we = 1'b1; r_wa = g_q[RW-1:0]; r_wd = {1'b0, slot_q};
        pp_d = 16'(g_q); ps_d = 17'(b_q); pr_d = reps_q;
        g_d = g_q + 1'b1;
        full_d = (g_d >= (GW+1)'(GRAMMAR_DEPTH));
        pf_d = full_d;
        st_d = dgb_pkg::ST_DONE;
      end
      dgb_pkg::ST_DONE: begin
        if (full_q) begin
          clr_d = '0; st_d = dgb_pkg::ST_CLR;
        end else st_d = dgb_pkg::ST_OUT;
      end
      dgb_pkg::ST_OUT: begin
        // load the output register once the previous transaction has left
        if (!ov_q || out_if.ready) begin
          op_d = pp_q; os_d = ps_q; orc_d = pr_q; of_d = pf_q;
          ov_d = 1'b1; full_d = 1'b0; st_d = dgb_pkg::ST_IDLE;
        end
      end
      default: st_d = dgb_pkg::ST_CLR;
    endcase
  end

  `DGB_ASSERT_IMP(a_acc_idle, clk_i, rst_ni, in_if.valid && in_if.ready, st_q == dgb_pkg::ST_IDLE)
  `DGB_ASSERT_NXT(a_pop_clr, clk_i, rst_ni, hit_ok, st_q == dgb_pkg::ST_POP_CLR)
  `DGB_ASSERT_IMP(a_pos_range, clk_i, rst_ni, st_q == dgb_pkg::ST_IDLE, g_q >= (GW+1)'(dgb_pkg::FirstPos))
endmodule
